// ===== sv/bscfn_pkg.sv =====
// Shared constants and types for the bitmap set/clear/find-next block.
// No dependencies; every other file in this folder imports this package.
package bscfn_pkg;

	localparam int NUM_WORDS_DEF = 32;
	localparam int WORD_W        = 32;
	localparam int BIT_W         = 5;
	localparam int IDX_W         = 10;
	localparam int SIZE_W        = 11;
	localparam int CMD_W         = 3;
	localparam int MAX_WORDS     = 32;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_TEST      = 3'd0,
		CMD_SET       = 3'd1,
		CMD_CLEAR     = 3'd2,
		CMD_TOGGLE    = 3'd3,
		CMD_FIND_SET  = 3'd4,
		CMD_FIND_CLR  = 3'd5,
		CMD_FILL      = 3'd6
	} cmd_t;

	typedef struct packed {
		logic en;
		logic val;
	} fill_req_t;

endpackage

// ===== sv/bitmap_set_clear_find_next.sv =====
// Top level of the bitmap block: command sequencer, size register and result registers.
// Depends on bscfn_pkg, bscfn_store and bscfn_ffs.
//
//   Channel   Handshake            Payload
//   command   start / busy         cmd, bit_index, fill_value
//   result    done (strobe)        bit_value, found, found_index, error
//   config    cfg_wr_en            cfg_wr_data (size in use)
//
// A command is taken when start is high and busy is low; busy stays high until the
// result beat. Fill and rejected commands go from decode straight to the result beat;
// test/set/clear/toggle add a registered word read (a write back for all but test).
// A search scans one word per cycle through the find-first-set unit, from the start
// word to the last word in use. Reset clears the map to zero at once through per-word
// valid bits; no sweep is needed. The result beat lasts one cycle and cannot be held off.
module bitmap_set_clear_find_next #(
	parameter int NUM_WORDS = bscfn_pkg::NUM_WORDS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [bscfn_pkg::CMD_W-1:0]   cmd,
	input  logic [bscfn_pkg::IDX_W-1:0]   bit_index,
	input  logic                          fill_value,
	output logic                          done,
	output logic                          bit_value,
	output logic                          found,
	output logic [bscfn_pkg::IDX_W-1:0]   found_index,
	output logic                          error,
	input  logic                          cfg_wr_en,
	input  logic [bscfn_pkg::SIZE_W-1:0]  cfg_wr_data
);
	import bscfn_pkg::*;

	// Bits past index 1023 can never be addressed, so at most 32 words are kept.
	localparam int STORE_WORDS = (NUM_WORDS < MAX_WORDS) ? NUM_WORDS : MAX_WORDS;
	localparam int WAW         = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam logic [SIZE_W-1:0] STORE_BITS = SIZE_W'(STORE_WORDS * WORD_W);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_RMW    = 5'b00100,
		ST_SCAN   = 5'b01000,
		ST_RESULT = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	cmd_t               cmd_q;
	logic [IDX_W-1:0]   idx_q;
	logic               fv_q;
	logic [SIZE_W-1:0]  size_q;
	logic [WAW:0]       ptr_q, ptr_d;
	logic [WAW-1:0]     word_s1;
	logic               bit_value_q, found_q, error_q;
	logic [IDX_W-1:0]   found_index_q;

	logic [SIZE_W-1:0]  lim, lim_m1;
	logic [WAW-1:0]     start_word, last_word;
	logic [BIT_W-1:0]   start_bit;
	logic               idx_bad;

	logic               rd_en, wr_en;
	logic [WAW-1:0]     rd_addr;
	logic [WORD_W-1:0]  rd_data, wr_data;
	fill_req_t          fill;

	logic [WORD_W-1:0]  scan_vec, bit_mask;
	logic               ffs_hit;
	logic [BIT_W-1:0]   ffs_pos;

	logic               res_load, res_bv, res_found, res_err;
	logic [IDX_W-1:0]   res_idx;

	assign lim        = (size_q > STORE_BITS) ? STORE_BITS : size_q;
	assign lim_m1     = lim - SIZE_W'(1);
	assign last_word  = lim_m1[WAW+BIT_W-1:BIT_W];
	assign start_word = idx_q[WAW+BIT_W-1:BIT_W];
	assign start_bit  = idx_q[BIT_W-1:0];
	assign idx_bad    = SIZE_W'(idx_q) >= lim;
	assign bit_mask   = WORD_W'(1) << start_bit;

	// Search word: matching bits turned to ones, then bits before the start and
	// at or beyond the size in use masked off.
	always_comb begin
		scan_vec = (cmd_q == CMD_FIND_SET) ? rd_data : ~rd_data;
		if (word_s1 == start_word) begin
			scan_vec = scan_vec & ({WORD_W{1'b1}} << start_bit);
		end
		if (6'(word_s1) >= lim[SIZE_W-1:BIT_W]) begin
			scan_vec = scan_vec & ~({WORD_W{1'b1}} << lim[BIT_W-1:0]);
		end
	end

	bscfn_ffs u_ffs (
		.vec (scan_vec),
		.hit (ffs_hit),
		.pos (ffs_pos)
	);

	bscfn_store #(
		.STORE_WORDS (STORE_WORDS)
	) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (start_word),
		.wr_data (wr_data),
		.fill    (fill)
	);

	always_comb begin
		state_d   = state_q;
		ptr_d     = ptr_q;
		rd_en     = 1'b0;
		rd_addr   = start_word;
		wr_en     = 1'b0;
		wr_data   = rd_data;
		fill.en   = 1'b0;
		fill.val  = fv_q;
		res_load  = 1'b0;
		res_bv    = 1'b0;
		res_found = 1'b0;
		res_err   = 1'b0;
		res_idx   = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (cmd_q)
					CMD_FILL: begin
						fill.en  = 1'b1;
						res_load = 1'b1;
						state_d  = ST_RESULT;
					end
					CMD_TEST, CMD_SET, CMD_CLEAR, CMD_TOGGLE: begin
						if (idx_bad) begin
							res_err  = 1'b1;
							res_load = 1'b1;
							state_d  = ST_RESULT;
						end else begin
							rd_en   = 1'b1;
							state_d = ST_RMW;
						end
					end
					CMD_FIND_SET, CMD_FIND_CLR: begin
						if (idx_bad) begin
							res_err  = 1'b1;
							res_load = 1'b1;
							state_d  = ST_RESULT;
						end else begin
							rd_en   = 1'b1;
							ptr_d   = (WAW+1)'(start_word) + (WAW+1)'(1);
							state_d = ST_SCAN;
						end
					end
					default: begin
						res_load = 1'b1;
						state_d  = ST_RESULT;
					end
				endcase
			end
			ST_RMW: begin
				res_bv   = |(rd_data & bit_mask);
				res_load = 1'b1;
				state_d  = ST_RESULT;
				case (cmd_q)
					CMD_SET: begin
						wr_en   = 1'b1;
						wr_data = rd_data | bit_mask;
					end
					CMD_CLEAR: begin
						wr_en   = 1'b1;
						wr_data = rd_data & ~bit_mask;
					end
					CMD_TOGGLE: begin
						wr_en   = 1'b1;
						wr_data = rd_data ^ bit_mask;
					end
					default: begin
						wr_en = 1'b0;
					end
				endcase
			end
			ST_SCAN: begin
				// Reads run one word ahead of the word being searched.
				rd_addr = ptr_q[WAW-1:0];
				if (ptr_q <= (WAW+1)'(last_word)) begin
					rd_en = 1'b1;
					ptr_d = ptr_q + (WAW+1)'(1);
				end
				if (ffs_hit) begin
					res_found = 1'b1;
					res_idx   = IDX_W'({word_s1, ffs_pos});
					res_load  = 1'b1;
					state_d   = ST_RESULT;
				end else if (word_s1 == last_word) begin
					res_load = 1'b1;
					state_d  = ST_RESULT;
				end
			end
			ST_RESULT: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			size_q  <= SIZE_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				size_q <= cfg_wr_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd_t'(cmd);
			idx_q <= bit_index;
			fv_q  <= fill_value;
		end
		ptr_q <= ptr_d;
		if (rd_en) begin
			word_s1 <= rd_addr;
		end
		if (res_load) begin
			bit_value_q   <= res_bv;
			found_q       <= res_found;
			found_index_q <= res_idx;
			error_q       <= res_err;
		end
	end

	assign busy        = state_q != ST_IDLE;
	assign done        = state_q == ST_RESULT;
	assign bit_value   = bit_value_q;
	assign found       = found_q;
	assign found_index = found_index_q;
	assign error       = error_q;

endmodule

// ===== sv/bscfn_store.sv =====
// Word store for the bitmap: one write port, one registered read port.
// Per-word valid bits stand in for a clearing pass; unwritten words read as the fill value.
// Depends on bscfn_pkg.
module bscfn_store #(
	parameter int STORE_WORDS = bscfn_pkg::MAX_WORDS
) (
	input  logic                                                  clk,
	input  logic                                                  arst_n,
	input  logic                                                  rd_en,
	input  logic [(STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1)-1:0] rd_addr,
	output logic [bscfn_pkg::WORD_W-1:0]                          rd_data,
	input  logic                                                  wr_en,
	input  logic [(STORE_WORDS > 1 ? $clog2(STORE_WORDS) : 1)-1:0] wr_addr,
	input  logic [bscfn_pkg::WORD_W-1:0]                          wr_data,
	input  bscfn_pkg::fill_req_t                                  fill
);
	import bscfn_pkg::*;

	logic [WORD_W-1:0]      mem_q [STORE_WORDS];
	logic [STORE_WORDS-1:0] vld_q;
	logic                   fill_q;
	logic [WORD_W-1:0]      rd_word_s1;
	logic                   rd_vld_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_word_s1 <= mem_q[rd_addr];
			rd_vld_s1  <= vld_q[rd_addr];
		end
	end

	// A fill marks every word stale; stale words read back as the fill value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			fill_q <= 1'b0;
		end else if (fill.en) begin
			vld_q  <= '0;
			fill_q <= fill.val;
		end else if (wr_en) begin
			vld_q[wr_addr] <= 1'b1;
		end
	end

	assign rd_data = rd_vld_s1 ? rd_word_s1 : {WORD_W{fill_q}};

endmodule

// ===== sv/bscfn_ffs.sv =====
// Find-first-set unit: lowest set bit of one masked 32-bit word.
// Shared by both searches, one word per cycle. Depends on bscfn_pkg.
module bscfn_ffs (
	input  logic [bscfn_pkg::WORD_W-1:0] vec,
	output logic                         hit,
	output logic [bscfn_pkg::BIT_W-1:0]  pos
);
	import bscfn_pkg::*;

	always_comb begin
		hit = 1'b0;
		pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (vec[i]) begin
				hit = 1'b1;
				pos = BIT_W'(i);
			end
		end
	end

endmodule

// ===== sv/bscfn_chk.sv =====
// Port-level checker for the bitmap block, attached to the top level by bind.
// Depends on bscfn_pkg and the top level's port list.
module bscfn_chk (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  logic                          done,
	input  logic                          bit_value,
	input  logic                          found,
	input  logic [bscfn_pkg::IDX_W-1:0]   found_index,
	input  logic                          error
);
	import bscfn_pkg::*;

	// A result beat only ends a command that is still in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result beat while idle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy && !done) else $error("accepted command not held");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done && !busy) else $error("result beat longer than one cycle");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		done && error |-> !found && !bit_value && found_index == '0)
		else $error("error beat carries data");

	a_idx_found: assert property (@(posedge clk) disable iff (!arst_n)
		done && found_index != '0 |-> found) else $error("index without a hit");

endmodule

bind bitmap_set_clear_find_next bscfn_chk u_bscfn_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.done        (done),
	.bit_value   (bit_value),
	.found       (found),
	.found_index (found_index),
	.error       (error)
);

// ===== tb/bitmap_set_clear_find_next_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bitmap_set_clear_find_next: directed and random commands with
// a bit-accurate model of the map, checked beat by beat. Depends on bscfn_pkg and the RTL.
module bitmap_set_clear_find_next_test;
	import bscfn_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;
	localparam int MAP_BITS       = NUM_WORDS_DEF * WORD_W;
	localparam int INDEX_SPAN     = 1 << IDX_W;
	localparam int SETTLE_CYCLES  = 40;
	localparam int WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [CMD_W-1:0] op;
		logic [IDX_W-1:0] idx;
		logic             fv;
	} bitmap_cmd_t;

	typedef struct packed {
		logic             bit_value;
		logic             found;
		logic [IDX_W-1:0] found_index;
		logic             error;
	} bitmap_result_t;

	typedef struct packed {
		bitmap_cmd_t    beat;
		bitmap_result_t res;
	} bitmap_outcome_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic [CMD_W-1:0]  cmd = '0;
	logic [IDX_W-1:0]  bit_index = '0;
	logic              fill_value = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [SIZE_W-1:0] cfg_wr_data = '0;
	logic              busy, done, bit_value, found, error;
	logic [IDX_W-1:0]  found_index;

	logic [MAP_BITS-1:0] map_model = '0;
	logic [SIZE_W-1:0]   size_model = SIZE_RESET;
	bitmap_cmd_t         pending_cmds[$];
	bitmap_outcome_t     predicted_outcomes[$];
	bitmap_cmd_t         next_beat;
	bitmap_outcome_t     new_outcome;
	bit                  took_beat = 1'b0;
	bit                  gaps_on = 1'b1;
	int                  gap_left = 0;
	int                  idle_cycles = 0;
	int                  mismatch_count = 0;

	bitmap_set_clear_find_next u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.cmd         (cmd),
		.bit_index   (bit_index),
		.fill_value  (fill_value),
		.done        (done),
		.bit_value   (bit_value),
		.found       (found),
		.found_index (found_index),
		.error       (error),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int effective_size();
		int lim;
		lim = int'(size_model);
		if (lim > MAP_BITS) lim = MAP_BITS;
		if (lim > INDEX_SPAN) lim = INDEX_SPAN;
		return lim;
	endfunction

	// Applies one command to the model map and returns the result it must produce.
	function automatic bitmap_result_t bitmap_apply(logic [CMD_W-1:0] op, logic [IDX_W-1:0] idx,
			logic fv);
		bitmap_result_t r;
		int lim;
		int i;
		r = '0;
		lim = effective_size();
		if (op == CMD_FILL) begin
			map_model = {MAP_BITS{fv}};
		end else if (op != CMD_SPARE) begin
			if (int'(idx) >= lim) begin
				r.error = 1'b1;
			end else if (op == CMD_FIND_SET || op == CMD_FIND_CLR) begin
				for (i = int'(idx); i < lim && !r.found; i++) begin
					if (map_model[i] == (op == CMD_FIND_SET)) begin
						r.found = 1'b1;
						r.found_index = IDX_W'(i);
					end
				end
			end else begin
				r.bit_value = map_model[idx];
				case (op)
					CMD_SET: map_model[idx] = 1'b1;
					CMD_CLEAR: map_model[idx] = 1'b0;
					CMD_TOGGLE: map_model[idx] = ~map_model[idx];
					default: ;
				endcase
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	task automatic check_result();
		bitmap_outcome_t want;
		string tag;
		if (predicted_outcomes.size() == 0) begin
			report_mismatch("result beat with no command outstanding");
		end else begin
			want = predicted_outcomes.pop_front();
			tag = $sformatf("cmd %0d idx %0d fill %0d:", want.beat.op, want.beat.idx,
				want.beat.fv);
			if (bit_value !== want.res.bit_value)
				report_mismatch($sformatf("%s bit_value %b, expected %b", tag, bit_value,
					want.res.bit_value));
			if (found !== want.res.found)
				report_mismatch($sformatf("%s found %b, expected %b", tag, found,
					want.res.found));
			if (found_index !== want.res.found_index)
				report_mismatch($sformatf("%s found_index %0d, expected %0d", tag,
					found_index, want.res.found_index));
			if (error !== want.res.error)
				report_mismatch($sformatf("%s error %b, expected %b", tag, error,
					want.res.error));
		end
	endtask

	// Monitor: results are checked before a new command is predicted at the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done) check_result();
			took_beat = start && !busy;
			if (took_beat) begin
				new_outcome.beat = '{cmd, bit_index, fill_value};
				new_outcome.res = bitmap_apply(cmd, bit_index, fill_value);
				predicted_outcomes.push_back(new_outcome);
			end
			if (done || took_beat) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	// Driver: a presented command is held until it is taken, then the next one follows
	// unless a random gap is started.
	always @(negedge clk) begin
		if (arst_n && !(start && !took_beat)) begin
			if (gap_left > 0) begin
				gap_left--;
				start <= 1'b0;
			end else if (pending_cmds.size() != 0 && gaps_on && $urandom_range(0, 7) == 0) begin
				gap_left = $urandom_range(0, 12);
				start <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				next_beat = pending_cmds.pop_front();
				start <= 1'b1;
				cmd <= next_beat.op;
				bit_index <= next_beat.idx;
				fill_value <= next_beat.fv;
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic queue_cmd(logic [CMD_W-1:0] op, int idx, logic fv);
		pending_cmds.push_back('{op, IDX_W'(idx), fv});
	endtask

	task automatic wait_quiet();
		while (pending_cmds.size() != 0 || start || predicted_outcomes.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_size(int value);
		wait_quiet();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= SIZE_W'(value);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		size_model = SIZE_W'(value);
		@(posedge clk);
	endtask

	function automatic int pick_index(int lim, int base);
		int roll;
		roll = $urandom_range(0, 99);
		if (lim == 0 || roll < 8) return $urandom_range(0, INDEX_SPAN - 1);
		if (roll < 16) begin
			case ($urandom_range(0, 3))
				0: return 0;
				1: return lim - 1;
				2: return (lim < INDEX_SPAN) ? lim : INDEX_SPAN - 1;
				default: return INDEX_SPAN - 1;
			endcase
		end
		// A narrow window keeps sets, clears and searches working on the same bits.
		if (roll < 56) return ((base % lim) + $urandom_range(0, 47)) % lim;
		return $urandom_range(0, lim - 1);
	endfunction

	task automatic queue_random(int count);
		int lim;
		int base;
		int roll;
		int k;
		logic [CMD_W-1:0] op;
		lim = effective_size();
		base = $urandom_range(0, INDEX_SPAN - 1);
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			if (roll < 14) op = CMD_TEST;
			else if (roll < 32) op = CMD_SET;
			else if (roll < 46) op = CMD_CLEAR;
			else if (roll < 58) op = CMD_TOGGLE;
			else if (roll < 76) op = CMD_FIND_SET;
			else if (roll < 95) op = CMD_FIND_CLR;
			else if (roll < 98) op = CMD_FILL;
			else op = CMD_SPARE;
			queue_cmd(op, pick_index(lim, base), 1'($urandom_range(0, 1)));
		end
	endtask

	task automatic random_phase(int size, int count, bit gaps);
		write_size(size);
		gaps_on = gaps;
		queue_random(count);
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty map at the reset size, then single bits at word boundaries and the ends.
		queue_cmd(CMD_TEST, 0, 1'b0);
		queue_cmd(CMD_TEST, 1023, 1'b1);
		queue_cmd(CMD_FIND_SET, 0, 1'b0);
		queue_cmd(CMD_FIND_CLR, 1023, 1'b0);
		queue_cmd(CMD_SET, 0, 1'b0);
		queue_cmd(CMD_SET, 31, 1'b0);
		queue_cmd(CMD_SET, 32, 1'b1);
		queue_cmd(CMD_SET, 1023, 1'b0);
		queue_cmd(CMD_TOGGLE, 500, 1'b0);
		queue_cmd(CMD_TOGGLE, 500, 1'b1);
		queue_cmd(CMD_CLEAR, 31, 1'b0);
		queue_cmd(CMD_FIND_SET, 1, 1'b0);
		queue_cmd(CMD_FIND_SET, 33, 1'b0);
		queue_cmd(CMD_FIND_CLR, 0, 1'b0);
		queue_cmd(CMD_FILL, 1023, 1'b1);
		queue_cmd(CMD_FIND_CLR, 0, 1'b0);
		queue_cmd(CMD_CLEAR, 777, 1'b0);
		queue_cmd(CMD_FIND_CLR, 5, 1'b0);
		queue_cmd(CMD_TEST, 777, 1'b0);
		queue_cmd(CMD_SPARE, 1023, 1'b1);
		queue_cmd(CMD_SPARE, 0, 1'b0);
		queue_cmd(CMD_FILL, 0, 1'b0);

		// A size of zero rejects every bit and search command; fill still works.
		write_size(0);
		queue_cmd(CMD_TEST, 0, 1'b0);
		queue_cmd(CMD_FIND_SET, 0, 1'b1);
		queue_cmd(CMD_FILL, 512, 1'b1);

		// One valid bit; the rest of the filled map stays hidden until the size grows.
		write_size(1);
		queue_cmd(CMD_FIND_CLR, 0, 1'b0);
		queue_cmd(CMD_CLEAR, 0, 1'b0);
		queue_cmd(CMD_TEST, 1, 1'b0);

		// Sizes above the map are capped at the stored bits.
		write_size(2047);
		queue_cmd(CMD_FIND_SET, 0, 1'b0);
		queue_cmd(CMD_TEST, 1023, 1'b0);

		random_phase(1024, 150, 1'b1);
		random_phase(1, 60, 1'b1);
		random_phase(2047, 150, 1'b1);
		random_phase(64, 150, 1'b0);
		random_phase(33, 150, 1'b1);
		random_phase(0, 30, 1'b1);
		random_phase(1023, 150, 1'b1);
		random_phase(1025, 60, 1'b1);
		random_phase(513, 150, 1'b1);
		random_phase($urandom_range(1, 1024), 150, 1'b1);
		random_phase($urandom_range(0, 2047), 150, 1'b1);
		random_phase(1024, 150, 1'b0);

		wait_quiet();
		if (mismatch_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
